[src/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY  = 128;
  localparam int PRIO_W    = 32;
  localparam int PAYLOAD_W = 64;

  typedef enum logic {
    FN_INSERT  = 1'b0,
    FN_EXTRACT = 1'b1
  } spq_func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic ext;
  } spq_ctl_t;

endpackage

[src/spq_cell.sv]
module spq_cell (
  input  logic                                clk,
  input  spq_pkg::spq_ctl_t                   ctl,
  input  logic                                occupied,
  input  logic signed [spq_pkg::PRIO_W-1:0]   key,
  input  logic [spq_pkg::PAYLOAD_W-1:0]       new_payload,
  input  logic                                left_gt,
  input  logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
  input  logic [spq_pkg::PAYLOAD_W-1:0]       left_payload,
  input  logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
  input  logic [spq_pkg::PAYLOAD_W-1:0]       right_payload,
  output logic                                gt,
  output logic signed [spq_pkg::PRIO_W-1:0]   prio,
  output logic [spq_pkg::PAYLOAD_W-1:0]       payload
);

  logic signed [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [spq_pkg::PAYLOAD_W-1:0]     payload_r, payload_nxt;

  // An empty cell counts as greater, so a key that no stored priority exceeds lands after all stored ones.
  assign gt = !occupied || (prio_r > key);

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (ctl.ins && gt) begin
      if (left_gt) begin
        prio_nxt    = left_prio;
        payload_nxt = left_payload;
      end else begin
        prio_nxt    = key;
        payload_nxt = new_payload;
      end
    end else if (ctl.ext) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

[src/sorted_priority_queue.sv]
// Sorted min-priority queue of CAPACITY (priority, payload) pairs, one pair per
// cell of a linear chain, lowest priority in cell 0 and ties kept in arrival order.
// Every beat is one insert or one extract; all cells compare the new priority at
// once and shift by one place in the same cycle, so the block takes one beat per
// cycle unless stalled, with its result in the next cycle from the output register.
// The input stalls only while that register holds a result and the output is stalled.
// An insert into a full queue returns status full, an extract from an empty queue
// returns status empty; payload_out is zero for everything but a good extract.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [spq_pkg::PAYLOAD_W-1:0]       in_payload,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_prio,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [spq_pkg::PAYLOAD_W-1:0]       out_payload_out
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [OCC_W-1:0]                  occ_r, occ_nxt;
  logic                              out_valid_r, out_valid_nxt;
  spq_pkg::spq_status_t              status_r, status_nxt;
  logic [spq_pkg::PAYLOAD_W-1:0]     payload_r, payload_nxt;

  logic                              accept, full, empty;
  spq_pkg::spq_ctl_t                 ctl;

  logic                              cell_gt      [CAPACITY];
  logic                              cell_occ     [CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0] cell_prio    [CAPACITY];
  logic [spq_pkg::PAYLOAD_W-1:0]     cell_payload [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (occ_r == OCC_W'(CAPACITY));
  assign empty    = (occ_r == '0);

  assign ctl.ins = accept && (in_func == spq_pkg::FN_INSERT) && !full;
  assign ctl.ext = accept && (in_func == spq_pkg::FN_EXTRACT) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_gt;
    logic signed [spq_pkg::PRIO_W-1:0] l_prio, r_prio;
    logic [spq_pkg::PAYLOAD_W-1:0]     l_payload, r_payload;

    assign cell_occ[i] = (OCC_W'(i) < occ_r);

    if (i == 0) begin : g_head
      assign l_gt      = 1'b0;
      assign l_prio    = cell_prio[i];
      assign l_payload = cell_payload[i];
    end else begin : g_body
      assign l_gt      = cell_gt[i-1];
      assign l_prio    = cell_prio[i-1];
      assign l_payload = cell_payload[i-1];
    end

    // The tail cell has no right neighbor; it falls out of range on extract anyway.
    if (i == CAPACITY - 1) begin : g_tail
      assign r_prio    = cell_prio[i];
      assign r_payload = cell_payload[i];
    end else begin : g_mid
      assign r_prio    = cell_prio[i+1];
      assign r_payload = cell_payload[i+1];
    end

    spq_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (cell_occ[i]),
      .key           (in_prio),
      .new_payload   (in_payload),
      .left_gt       (l_gt),
      .left_prio     (l_prio),
      .left_payload  (l_payload),
      .right_prio    (r_prio),
      .right_payload (r_payload),
      .gt            (cell_gt[i]),
      .prio          (cell_prio[i]),
      .payload       (cell_payload[i])
    );
  end

  always_comb begin
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    payload_nxt   = payload_r;
    if (ctl.ins) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (ctl.ext) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      payload_nxt   = '0;
      case (in_func)
        spq_pkg::FN_INSERT: begin
          status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end
        spq_pkg::FN_EXTRACT: begin
          status_nxt = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
          if (!empty) begin
            payload_nxt = cell_payload[0];
          end
        end
        default: begin
          status_nxt = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    payload_r <= payload_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_payload_out = payload_r;

endmodule
